// File: src/aamr_pkg.sv
// ----------------------------------------------------------------------------
// aamr_pkg
// Shared types and constants for the argmin/argmax axis reduction block.
// ----------------------------------------------------------------------------
`default_nettype none

package aamr_pkg;

    // Configuration port
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_SIGNED = 2'd1;
    localparam logic [1:0] REG_INNER  = 2'd2;
    localparam logic [1:0] REG_MID    = 2'd3;

    localparam int MODE_W  = 2;
    localparam int INNER_W = 11;
    localparam int MID_W   = 17;

    // Mode codes
    localparam logic [1:0] MODE_FIRST_MIN = 2'd0;
    localparam logic [1:0] MODE_LAST_MIN  = 2'd1;
    localparam logic [1:0] MODE_FIRST_MAX = 2'd2;
    localparam logic [1:0] MODE_LAST_MAX  = 2'd3;

    // Stream payloads
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int INDEX_W     = 16;
    localparam int POS_W       = 10;

    // Result buffer
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic                row_done;
        logic [POS_W-1:0]    inner_position;
        logic [INDEX_W-1:0]  best_index;
    } out_item_t;

endpackage

`default_nettype wire

// File: src/axis_argmin_argmax_reduce.sv
// ----------------------------------------------------------------------------
// axis_argmin_argmax_reduce
// Streaming argmin/argmax along one tensor axis, per inner position.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                Contents
//  -------   ---  -----------------------  ----------------------------------
//  s_axis    in   tvalid/tready            tdata = sample_value
//  m_axis    out  tvalid/tready            tdata = best_index, inner_position;
//                                          tlast = row_done
//  apb       in   psel/penable/pready      mode, value_signed, inner_count,
//                                          mid_count at 0x0/0x4/0x8/0xC
//
//  Cycles: one sample per clock while the buffer has room. A sample reads
//  its position's entry in the best-value/best-slot memory on the accept
//  edge, compares and writes back in the cycle after; a write-to-read bypass
//  covers back-to-back hits on the same entry.
//  Reset: counters and buffer clear at once; the memory is not cleared, since
//  slice 0 always loads each entry before its stored value is used.
//  Stalls: up to four results queue in the output buffer; s_axis_tready drops
//  when buffered results plus a stage-1 sample would fill it.
//
`default_nettype none

module axis_argmin_argmax_reduce #(
    parameter int INNER_MAX  = 1024,
    parameter int SLICE_MAX  = 65536,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [aamr_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [31:0] sample_value

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [aamr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [15:0] best_index,
                                                                 // [25:16] inner_position
    output logic                                 m_axis_tlast,   // row_done

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [aamr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [aamr_pkg::PDATA_W-1:0]    pwdata,
    output logic [aamr_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import aamr_pkg::*;

    localparam int IW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int SW = $clog2(SLICE_MAX);
    localparam int VW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int EW = SW + VW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  mode_reg;
    logic               value_signed_reg;
    logic [INNER_W-1:0] inner_count_reg;
    logic [MID_W-1:0]   mid_count_reg;

    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic               geom_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign geom_wr = cfg_wr && ((cfg_idx == REG_INNER) || (cfg_idx == REG_MID));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_FIRST_MIN;
            value_signed_reg <= 1'b0;
            inner_count_reg  <= INNER_W'(1);
            mid_count_reg    <= MID_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODE:   mode_reg         <= pwdata[MODE_W-1:0];
                REG_SIGNED: value_signed_reg <= pwdata[0];
                REG_INNER:  inner_count_reg  <= pwdata[INNER_W-1:0];
                REG_MID:    mid_count_reg    <= pwdata[MID_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MODE:   prdata = PDATA_W'(mode_reg);
            REG_SIGNED: prdata = PDATA_W'(value_signed_reg);
            REG_INNER:  prdata = PDATA_W'(inner_count_reg);
            REG_MID:    prdata = PDATA_W'(mid_count_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective geometry: zero acts as one, oversize clamps to the maximum.
    logic [31:0]   inner_eff;
    logic [31:0]   mid_eff;
    logic [IW-1:0] inner_last;
    logic [SW-1:0] mid_last;

    always_comb
    begin
        if (inner_count_reg == '0)
            inner_eff = 32'd1;
        else if (32'(inner_count_reg) > 32'(INNER_MAX))
            inner_eff = 32'(INNER_MAX);
        else
            inner_eff = 32'(inner_count_reg);

        if (mid_count_reg == '0)
            mid_eff = 32'd1;
        else if (32'(mid_count_reg) > 32'(SLICE_MAX))
            mid_eff = 32'(SLICE_MAX);
        else
            mid_eff = 32'(mid_count_reg);
    end

    assign inner_last = IW'(inner_eff - 32'd1);
    assign mid_last   = SW'(mid_eff - 32'd1);

    // ------------------------------------------------------------------
    // Stage 0: position counters, memory read issue
    // ------------------------------------------------------------------
    logic          s_fire;
    logic [IW-1:0] inner_ctr_reg, inner_ctr_next;
    logic [SW-1:0] slice_ctr_reg, slice_ctr_next;
    logic          pos_is_last;
    logic          slice_is_last;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign pos_is_last   = (inner_ctr_reg == inner_last);
    assign slice_is_last = (slice_ctr_reg == mid_last);

    always_comb
    begin
        inner_ctr_next = inner_ctr_reg;
        slice_ctr_next = slice_ctr_reg;
        if (geom_wr)
        begin
            inner_ctr_next = '0;
            slice_ctr_next = '0;
        end
        else if (s_fire)
        begin
            if (pos_is_last)
            begin
                inner_ctr_next = '0;
                slice_ctr_next = slice_is_last ? '0 : slice_ctr_reg + SW'(1);
            end
            else
            begin
                inner_ctr_next = inner_ctr_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_ctr_reg <= '0;
            slice_ctr_reg <= '0;
        end
        else
        begin
            inner_ctr_reg <= inner_ctr_next;
            slice_ctr_reg <= slice_ctr_next;
        end
    end

    // Per-position store: {best_slot, best_value}
    logic [EW-1:0] best_mem [INNER_MAX];
    logic [EW-1:0] mem_rd_reg;
    logic          mem_we;
    logic [EW-1:0] mem_wdata;

    // Stage 1 registers
    logic          s1_valid_reg;
    logic [IW-1:0] s1_pos_reg;
    logic [SW-1:0] s1_slice_reg;
    logic [VW-1:0] s1_value_reg;
    logic          s1_first_reg;
    logic          s1_emit_reg;
    logic          s1_row_reg;

    // Bypass of the write made on the edge the current stage-1 item was read
    logic          fwd_valid_reg;
    logic [IW-1:0] fwd_addr_reg;
    logic [EW-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (s_fire)
            mem_rd_reg <= best_mem[inner_ctr_reg];
        if (mem_we)
            best_mem[s1_pos_reg] <= mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s_fire;
            fwd_valid_reg <= mem_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_pos_reg   <= inner_ctr_reg;
            s1_slice_reg <= slice_ctr_reg;
            s1_value_reg <= VW'(s_axis_tdata);
            s1_first_reg <= (slice_ctr_reg == '0);
            s1_emit_reg  <= slice_is_last;
            s1_row_reg   <= pos_is_last;
        end
        if (mem_we)
        begin
            fwd_addr_reg <= s1_pos_reg;
            fwd_data_reg <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: compare and write back
    // ------------------------------------------------------------------
    logic [EW-1:0] held;
    logic [VW-1:0] held_value;
    logic [SW-1:0] held_slot;
    logic [VW-1:0] sign_flip;
    logic [VW-1:0] key_new;
    logic [VW-1:0] key_held;
    logic          wins;
    logic          take;
    logic [SW-1:0] result_slot;

    assign held       = (fwd_valid_reg && (fwd_addr_reg == s1_pos_reg)) ? fwd_data_reg
                                                                        : mem_rd_reg;
    assign held_value = held[VW-1:0];
    assign held_slot  = held[EW-1:VW];

    // Signed order maps onto unsigned order by flipping the sign bit.
    assign sign_flip = VW'(value_signed_reg) << (VW - 1);
    assign key_new   = s1_value_reg ^ sign_flip;
    assign key_held  = held_value ^ sign_flip;

    always_comb
    begin
        case (mode_reg)
            MODE_FIRST_MIN: wins = key_new <  key_held;
            MODE_LAST_MIN:  wins = key_new <= key_held;
            MODE_FIRST_MAX: wins = key_new >  key_held;
            MODE_LAST_MAX:  wins = key_new >= key_held;
            default:        wins = 1'b0;
        endcase
    end

    assign take        = s1_first_reg || wins;
    assign mem_we      = s1_valid_reg && take;
    assign mem_wdata   = {s1_slice_reg, s1_value_reg};
    assign result_slot = take ? s1_slice_reg : held_slot;

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    out_item_t              out_buf [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   push;
    logic                   pop;
    out_item_t              push_item;
    out_item_t              head;

    assign push = s1_valid_reg && s1_emit_reg;
    assign pop  = m_axis_tvalid && m_axis_tready;

    assign push_item.best_index     = INDEX_W'(result_slot);
    assign push_item.inner_position = POS_W'(s1_pos_reg);
    assign push_item.row_done       = s1_row_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            out_buf[wr_ptr_reg] <= push_item;
    end

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + OUT_CNT_W'(1);
            2'b01:   count_next = count_reg - OUT_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Room for the stage-1 result and one more behind it.
    assign s_axis_tready = (count_reg + OUT_CNT_W'(s1_valid_reg)) < OUT_CNT_W'(OUT_DEPTH);

    assign head          = out_buf[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = OUT_TDATA_W'({head.inner_position, head.best_index});
    assign m_axis_tlast  = head.row_done;

endmodule

`default_nettype wire

// File: src/aamr_checker.sv
// ----------------------------------------------------------------------------
// aamr_checker
// Port-level checks for axis_argmin_argmax_reduce, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aamr_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [aamr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                            m_axis_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [aamr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [aamr_pkg::PDATA_W-1:0]    pwdata,
    input  wire logic [aamr_pkg::PDATA_W-1:0]    prdata,
    input  wire logic                            pready
);
    import aamr_pkg::*;

    logic              seen_input_reg;
    logic              after_row_reg;
    logic [MODE_W-1:0] mode_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_input_reg  <= 1'b0;
            after_row_reg   <= 1'b0;
            mode_shadow_reg <= MODE_FIRST_MIN;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                seen_input_reg <= 1'b1;
            if (m_axis_tvalid && m_axis_tready)
                after_row_reg <= m_axis_tlast;
            if (psel && penable && pwrite && pready && (paddr[3:2] == REG_MODE))
                mode_shadow_reg <= pwdata[MODE_W-1:0];
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // No result before any sample arrives.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_input_reg |-> !m_axis_tvalid)
        else $error("result without input");

    // A new output row starts at inner position zero.
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && after_row_reg |-> m_axis_tdata[25:16] == '0)
        else $error("row did not restart at position zero");

    // Mode reads back as last written.
    a_mode_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[3:2] == REG_MODE) |->
            prdata[MODE_W-1:0] == mode_shadow_reg)
        else $error("mode readback mismatch");

endmodule

bind axis_argmin_argmax_reduce aamr_checker u_aamr_checker (.*);

`default_nettype wire
